>>> rtl/gbec_pkg.sv
// Shared types and constants of the bilinear grid interpolator.
// Used by the axis mapper and the top level; depends on nothing.
package gbec_pkg;

    // Fixed widths of the coordinate, scale and count fields.
    localparam int COORD_W = 32;
    localparam int SCALE_W = 31;
    localparam int CNT_W   = 7;
    localparam int FIELD_W = 6;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd5;

    // Reset values of the origin and scale registers (1.0 in Q16.16 and Q15.16).
    localparam logic [COORD_W-1:0] ORIGIN_RESET = 32'h0001_0000;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 31'h0001_0000;
    localparam int                 COUNT_RESET  = 64;

    // Item kinds carried on tuser of the input stream.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Depth of the result queue; also the credit limit on queries in flight.
    localparam int OUT_FIFO_DEPTH = 16;

endpackage

>>> rtl/gbec_axis_map.sv
// Maps one coordinate axis to clamped neighbour indices and a fraction weight.
// Four register stages: difference, product, fixed-point index, bounds and clamp.
// Depends on gbec_pkg.
module gbec_axis_map #(
    parameter int FRACTION_BITS = 16,
    parameter int IDX_W         = 6
) (
    input  logic                                 i_clk,
    input  logic signed [gbec_pkg::COORD_W-1:0]  i_coord,
    input  logic signed [gbec_pkg::COORD_W-1:0]  i_origin,
    input  logic        [gbec_pkg::SCALE_W-1:0]  i_scale,
    input  logic        [gbec_pkg::CNT_W-1:0]    i_count,
    output logic                                 o_defined,
    output logic        [IDX_W-1:0]              o_lo,
    output logic        [IDX_W-1:0]              o_hi,
    output logic        [FRACTION_BITS-1:0]      o_frac
);

    localparam int DIFF_W = gbec_pkg::COORD_W + 1;
    localparam int PROD_W = DIFF_W + gbec_pkg::SCALE_W + 1;
    localparam int C_W    = PROD_W + 1 - FRACTION_BITS;
    localparam int PAD_W  = C_W - gbec_pkg::CNT_W - FRACTION_BITS;

    localparam logic signed [C_W-1:0] ONE_C  = C_W'(1) << FRACTION_BITS;
    localparam logic signed [C_W-1:0] HALF_C = C_W'(1) << (FRACTION_BITS - 1);

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic        [C_W-1:0]    r_c;
    logic        [C_W-1:0]    n_c;
    logic        [C_W-1:0]    w_top_bound;
    logic [gbec_pkg::CNT_W-1:0] w_bot;
    logic [gbec_pkg::CNT_W-1:0] w_lo7;
    logic [gbec_pkg::CNT_W-1:0] w_hi7;
    logic                       n_defined;

    // The arithmetic shift of the product rounds toward minus infinity.
    assign n_c = {r_prod[PROD_W-1], r_prod[PROD_W-1:FRACTION_BITS]} + ONE_C;

    // Upper bound n + 0.5 in the same fixed-point format.
    assign w_top_bound = {{PAD_W{1'b0}}, i_count, 1'b1, {(FRACTION_BITS-1){1'b0}}};

    // Only meaningful when the index is in bounds, where it lies in [0, n].
    assign w_bot = r_c[FRACTION_BITS+gbec_pkg::CNT_W-1:FRACTION_BITS];

    always_comb begin
        n_defined = ($signed(r_c) >= HALF_C) && ($signed(r_c) <= $signed(w_top_bound));
        w_lo7     = (w_bot == '0) ? '0 : w_bot - 7'd1;
        w_hi7     = (w_bot >= i_count) ? i_count - 7'd1 : w_bot;
    end

    always_ff @(posedge i_clk) begin
        r_diff    <= DIFF_W'(i_coord) - DIFF_W'(i_origin);
        r_prod    <= r_diff * $signed({1'b0, i_scale});
        r_c       <= n_c;
        o_defined <= n_defined;
        o_lo      <= IDX_W'(w_lo7);
        o_hi      <= IDX_W'(w_hi7);
        o_frac    <= r_c[FRACTION_BITS-1:0];
    end

endmodule

>>> rtl/gbec_grid_ram.sv
// Sample grid storage: two identical banks, each with one write port and two
// registered read ports, so four neighbours are read every cycle.
// No dependencies.
module gbec_grid_ram #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic        [$clog2(MAX_ROWS)-1:0]    i_wr_row,
    input  logic        [$clog2(MAX_COLUMNS)-1:0] i_wr_col,
    input  logic signed [SAMPLE_BITS-1:0]         i_wr_data,
    input  logic        [$clog2(MAX_ROWS)-1:0]    i_bot_row,
    input  logic        [$clog2(MAX_ROWS)-1:0]    i_top_row,
    input  logic        [$clog2(MAX_COLUMNS)-1:0] i_left_col,
    input  logic        [$clog2(MAX_COLUMNS)-1:0] i_right_col,
    output logic signed [SAMPLE_BITS-1:0]         o_bot_left,
    output logic signed [SAMPLE_BITS-1:0]         o_bot_right,
    output logic signed [SAMPLE_BITS-1:0]         o_top_left,
    output logic signed [SAMPLE_BITS-1:0]         o_top_right
);

    logic signed [SAMPLE_BITS-1:0] r_bank_bot [MAX_ROWS][MAX_COLUMNS];
    logic signed [SAMPLE_BITS-1:0] r_bank_top [MAX_ROWS][MAX_COLUMNS];

    // Both banks take every write, so they always hold the same grid.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_bank_bot[i_wr_row][i_wr_col] <= i_wr_data;
        end
        o_bot_left  <= r_bank_bot[i_bot_row][i_left_col];
        o_bot_right <= r_bank_bot[i_bot_row][i_right_col];
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_bank_top[i_wr_row][i_wr_col] <= i_wr_data;
        end
        o_top_left  <= r_bank_top[i_top_row][i_left_col];
        o_top_right <= r_bank_top[i_top_row][i_right_col];
    end

endmodule

>>> rtl/gbec_blend.sv
// Bilinear blend of four neighbour samples with exact intermediate products.
// Four register stages: horizontal products, horizontal sums, vertical product,
// rounding. No dependencies.
module gbec_blend #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic signed [SAMPLE_BITS-1:0]   i_bot_left,
    input  logic signed [SAMPLE_BITS-1:0]   i_bot_right,
    input  logic signed [SAMPLE_BITS-1:0]   i_top_left,
    input  logic signed [SAMPLE_BITS-1:0]   i_top_right,
    input  logic        [FRACTION_BITS-1:0] i_dc,
    input  logic        [FRACTION_BITS-1:0] i_dr,
    output logic        [SAMPLE_BITS-1:0]   o_value
);

    localparam int S    = SAMPLE_BITS;
    localparam int F    = FRACTION_BITS;
    localparam int HP_W = S + F + 2;
    localparam int AB_W = S + F + 2;
    localparam int PV_W = AB_W + F + 2;

    localparam logic signed [PV_W-1:0] ROUND_C = PV_W'(1) << (2 * F - 1);

    logic signed [S:0]      w_bot_delta;
    logic signed [S:0]      w_top_delta;
    logic signed [AB_W:0]   w_vert_delta;
    logic signed [PV_W-1:0] n_sum;

    logic signed [HP_W-1:0] r_bot_prod;
    logic signed [HP_W-1:0] r_top_prod;
    logic signed [S-1:0]    r_bot_left;
    logic signed [S-1:0]    r_top_left;
    logic        [F-1:0]    r_dr1;
    logic        [F-1:0]    r_dr2;
    logic signed [AB_W-1:0] r_ab;
    logic signed [AB_W-1:0] r_at;
    logic signed [AB_W-1:0] r_ab3;
    logic signed [PV_W-1:0] r_vert_prod;

    // a*(1-d) + b*d is computed as a*1 + (b-a)*d, which is the same exact value.
    always_comb begin
        w_bot_delta  = {i_bot_right[S-1], i_bot_right} - {i_bot_left[S-1], i_bot_left};
        w_top_delta  = {i_top_right[S-1], i_top_right} - {i_top_left[S-1], i_top_left};
        w_vert_delta = {r_at[AB_W-1], r_at} - {r_ab[AB_W-1], r_ab};
        n_sum        = $signed({{2{r_ab3[AB_W-1]}}, r_ab3, {F{1'b0}}}) + r_vert_prod + ROUND_C;
    end

    always_ff @(posedge i_clk) begin
        r_bot_prod  <= w_bot_delta * $signed({1'b0, i_dc});
        r_top_prod  <= w_top_delta * $signed({1'b0, i_dc});
        r_bot_left  <= i_bot_left;
        r_top_left  <= i_top_left;
        r_dr1       <= i_dr;

        r_ab        <= $signed({{2{r_bot_left[S-1]}}, r_bot_left, {F{1'b0}}}) + r_bot_prod;
        r_at        <= $signed({{2{r_top_left[S-1]}}, r_top_left, {F{1'b0}}}) + r_top_prod;
        r_dr2       <= r_dr1;

        r_vert_prod <= w_vert_delta * $signed({1'b0, r_dr2});
        r_ab3       <= r_ab;

        // The blend is a convex mix, so the rounded value fits the sample width.
        o_value     <= n_sum[2*F+S-1:2*F];
    end

endmodule

>>> rtl/gbec_out_fifo.sv
// Result queue between the interpolation pipeline and the output stream.
// Register array with read and write pointers. No dependencies.
module gbec_out_fifo #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_pop;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/grid_bilinear_edge_clamped.sv
// Top level of the bilinear grid interpolator with clamp-to-edge extrapolation.
// Instantiates gbec_axis_map, gbec_grid_ram, gbec_blend and gbec_out_fifo;
// uses gbec_pkg.
//
//  Channel   Direction  Handshake                 Content
//  s         in         i_s_tvalid / o_s_tready   sample write or query
//  m         out        o_m_tvalid / i_m_tready   interpolated value, defined flag
//  cfg       in         i_cfg_wr_en               register write, no wait
//
// One item is accepted per cycle while input ready is high. A query's result
// passes the axis mappers, the bank reads and the blend stages before it enters
// the result queue, and can leave the queue in the cycle after; the grid banks
// take a write and four reads every cycle, and writes reach the banks in the
// same stage as query reads, so item order is kept. Input ready drops only when
// the queries in flight plus the queued results reach the queue depth of 16.
// Reset empties the pipeline and queue and resets the configuration, not the grid.
module grid_bilinear_edge_clamped #(
    parameter int MAX_COLUMNS   = 64,
    parameter int MAX_ROWS      = 64,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // grid_row, grid_column, sample_value, x_coord, y_coord, zero fill
    input  logic [((76+SAMPLE_BITS+7)/8)*8-1:0]     i_s_tdata,
    // operation
    input  logic                                    i_s_tuser,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // interpolated_value, zero fill
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]        o_m_tdata,
    // is_defined
    output logic                                    o_m_tuser,
    input  logic                                    i_cfg_wr_en,
    input  logic [gbec_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [gbec_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int FW          = gbec_pkg::FIELD_W;
    localparam int CW          = gbec_pkg::CNT_W;
    localparam int SAMPLE_LSB  = 2 * FW;
    localparam int X_LSB       = SAMPLE_LSB + SAMPLE_BITS;
    localparam int Y_LSB       = X_LSB + gbec_pkg::COORD_W;
    localparam int DEPTH       = gbec_pkg::OUT_FIFO_DEPTH;
    localparam int CR_W        = $clog2(DEPTH + 1);
    localparam int MAP_STAGES  = 4;
    localparam int LAST_STAGE  = 9;

    localparam logic [CW-1:0] COL_LIMIT = (MAX_COLUMNS > 127) ? 7'd127 : CW'(MAX_COLUMNS);
    localparam logic [CW-1:0] ROW_LIMIT = (MAX_ROWS > 127) ? 7'd127 : CW'(MAX_ROWS);
    localparam logic [CW-1:0] COL_RESET =
        (gbec_pkg::COUNT_RESET > MAX_COLUMNS) ? COL_LIMIT : CW'(gbec_pkg::COUNT_RESET);
    localparam logic [CW-1:0] ROW_RESET =
        (gbec_pkg::COUNT_RESET > MAX_ROWS) ? ROW_LIMIT : CW'(gbec_pkg::COUNT_RESET);

    // Configuration registers.
    logic signed [gbec_pkg::COORD_W-1:0] r_x_origin;
    logic signed [gbec_pkg::COORD_W-1:0] r_y_origin;
    logic        [gbec_pkg::SCALE_W-1:0] r_x_scale;
    logic        [gbec_pkg::SCALE_W-1:0] r_y_scale;
    logic        [CW-1:0]                r_col_cnt;
    logic        [CW-1:0]                r_row_cnt;
    logic        [CW-1:0]                w_cfg_cnt;
    logic        [CW-1:0]                n_col_cnt;
    logic        [CW-1:0]                n_row_cnt;

    // Input fields.
    logic [FW-1:0]          w_row;
    logic [FW-1:0]          w_col;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic                   w_s_xfer;
    logic                   w_m_xfer;
    logic                   w_wr_ok;

    // Pipeline control and write payload.
    logic                   r_qry_v [1:LAST_STAGE];
    logic                   r_def   [5:LAST_STAGE];
    logic                   r_wr_v  [1:MAP_STAGES];
    logic [ROW_W-1:0]       r_wr_row [1:MAP_STAGES];
    logic [COL_W-1:0]       r_wr_col [1:MAP_STAGES];
    logic [SAMPLE_BITS-1:0] r_wr_data [1:MAP_STAGES];
    logic [CR_W-1:0]        r_credit;

    // Datapath between the units.
    logic                     w_x_def;
    logic                     w_y_def;
    logic [COL_W-1:0]         w_left;
    logic [COL_W-1:0]         w_right;
    logic [ROW_W-1:0]         w_bot;
    logic [ROW_W-1:0]         w_top;
    logic [FRACTION_BITS-1:0] w_dc;
    logic [FRACTION_BITS-1:0] w_dr;
    logic [FRACTION_BITS-1:0] r_dc;
    logic [FRACTION_BITS-1:0] r_dr;
    logic signed [SAMPLE_BITS-1:0] w_bot_left;
    logic signed [SAMPLE_BITS-1:0] w_bot_right;
    logic signed [SAMPLE_BITS-1:0] w_top_left;
    logic signed [SAMPLE_BITS-1:0] w_top_right;
    logic [SAMPLE_BITS-1:0]   w_blend;
    logic [SAMPLE_BITS-1:0]   w_result;
    logic [SAMPLE_BITS:0]     w_fifo_out;

    assign w_row    = i_s_tdata[FW-1:0];
    assign w_col    = i_s_tdata[2*FW-1:FW];
    assign w_sample = i_s_tdata[SAMPLE_LSB +: SAMPLE_BITS];

    assign o_s_tready = (r_credit != CR_W'(DEPTH));
    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_m_xfer   = o_m_tvalid && i_m_tready;

    // Writes outside the grid are dropped at the input.
    assign w_wr_ok = (int'(w_row) < MAX_ROWS) && (int'(w_col) < MAX_COLUMNS);

    // Counts are saturated to [1, limit] when written.
    always_comb begin
        w_cfg_cnt = i_cfg_data[CW-1:0];
        n_col_cnt = (w_cfg_cnt == '0) ? 7'd1 : ((w_cfg_cnt > COL_LIMIT) ? COL_LIMIT : w_cfg_cnt);
        n_row_cnt = (w_cfg_cnt == '0) ? 7'd1 : ((w_cfg_cnt > ROW_LIMIT) ? ROW_LIMIT : w_cfg_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= gbec_pkg::ORIGIN_RESET;
            r_y_origin <= gbec_pkg::ORIGIN_RESET;
            r_x_scale  <= gbec_pkg::SCALE_RESET;
            r_y_scale  <= gbec_pkg::SCALE_RESET;
            r_col_cnt  <= COL_RESET;
            r_row_cnt  <= ROW_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                gbec_pkg::REG_X_ORIGIN: begin
                    r_x_origin <= i_cfg_data;
                end
                gbec_pkg::REG_X_SCALE: begin
                    r_x_scale <= i_cfg_data[gbec_pkg::SCALE_W-1:0];
                end
                gbec_pkg::REG_Y_ORIGIN: begin
                    r_y_origin <= i_cfg_data;
                end
                gbec_pkg::REG_Y_SCALE: begin
                    r_y_scale <= i_cfg_data[gbec_pkg::SCALE_W-1:0];
                end
                gbec_pkg::REG_COLUMNS: begin
                    r_col_cnt <= n_col_cnt;
                end
                gbec_pkg::REG_ROWS: begin
                    r_row_cnt <= n_row_cnt;
                end
                default: begin
                end
            endcase
        end
    end

    // Valid bits of the pipeline stages and the query credit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAST_STAGE; k++) begin
                r_qry_v[k] <= 1'b0;
            end
            for (int k = 1; k <= MAP_STAGES; k++) begin
                r_wr_v[k] <= 1'b0;
            end
            r_credit <= '0;
        end else begin
            r_qry_v[1] <= w_s_xfer && (i_s_tuser == gbec_pkg::OP_QUERY);
            r_wr_v[1]  <= w_s_xfer && (i_s_tuser == gbec_pkg::OP_WRITE) && w_wr_ok;
            for (int k = 2; k <= LAST_STAGE; k++) begin
                r_qry_v[k] <= r_qry_v[k-1];
            end
            for (int k = 2; k <= MAP_STAGES; k++) begin
                r_wr_v[k] <= r_wr_v[k-1];
            end
            case ({w_s_xfer && (i_s_tuser == gbec_pkg::OP_QUERY), w_m_xfer})
                2'b10:   r_credit <= r_credit + 1'b1;
                2'b01:   r_credit <= r_credit - 1'b1;
                default: r_credit <= r_credit;
            endcase
        end
    end

    // Write payload travels alongside the coordinate mapping, so it reaches
    // the banks in the stage where queries issue their reads.
    always_ff @(posedge i_clk) begin
        r_wr_row[1]  <= ROW_W'(w_row);
        r_wr_col[1]  <= COL_W'(w_col);
        r_wr_data[1] <= w_sample;
        for (int k = 2; k <= MAP_STAGES; k++) begin
            r_wr_row[k]  <= r_wr_row[k-1];
            r_wr_col[k]  <= r_wr_col[k-1];
            r_wr_data[k] <= r_wr_data[k-1];
        end
        r_def[5] <= w_x_def && w_y_def;
        for (int k = 6; k <= LAST_STAGE; k++) begin
            r_def[k] <= r_def[k-1];
        end
        r_dc <= w_dc;
        r_dr <= w_dr;
    end

    gbec_axis_map #(
        .FRACTION_BITS (FRACTION_BITS),
        .IDX_W         (COL_W)
    ) u_map_x (
        .i_clk     (i_clk),
        .i_coord   (i_s_tdata[X_LSB +: gbec_pkg::COORD_W]),
        .i_origin  (r_x_origin),
        .i_scale   (r_x_scale),
        .i_count   (r_col_cnt),
        .o_defined (w_x_def),
        .o_lo      (w_left),
        .o_hi      (w_right),
        .o_frac    (w_dc)
    );

    gbec_axis_map #(
        .FRACTION_BITS (FRACTION_BITS),
        .IDX_W         (ROW_W)
    ) u_map_y (
        .i_clk     (i_clk),
        .i_coord   (i_s_tdata[Y_LSB +: gbec_pkg::COORD_W]),
        .i_origin  (r_y_origin),
        .i_scale   (r_y_scale),
        .i_count   (r_row_cnt),
        .o_defined (w_y_def),
        .o_lo      (w_bot),
        .o_hi      (w_top),
        .o_frac    (w_dr)
    );

    gbec_grid_ram #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_grid (
        .i_clk       (i_clk),
        .i_we        (r_wr_v[MAP_STAGES]),
        .i_wr_row    (r_wr_row[MAP_STAGES]),
        .i_wr_col    (r_wr_col[MAP_STAGES]),
        .i_wr_data   (r_wr_data[MAP_STAGES]),
        .i_bot_row   (w_bot),
        .i_top_row   (w_top),
        .i_left_col  (w_left),
        .i_right_col (w_right),
        .o_bot_left  (w_bot_left),
        .o_bot_right (w_bot_right),
        .o_top_left  (w_top_left),
        .o_top_right (w_top_right)
    );

    gbec_blend #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .i_clk       (i_clk),
        .i_bot_left  (w_bot_left),
        .i_bot_right (w_bot_right),
        .i_top_left  (w_top_left),
        .i_top_right (w_top_right),
        .i_dc        (r_dc),
        .i_dr        (r_dr),
        .o_value     (w_blend)
    );

    assign w_result = r_def[LAST_STAGE] ? w_blend : '0;

    gbec_out_fifo #(
        .DEPTH (DEPTH),
        .WIDTH (SAMPLE_BITS + 1)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_qry_v[LAST_STAGE]),
        .i_data  ({r_def[LAST_STAGE], w_result}),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (w_fifo_out)
    );

    assign o_m_tdata = OUT_TDATA_W'(w_fifo_out[SAMPLE_BITS-1:0]);
    assign o_m_tuser = w_fifo_out[SAMPLE_BITS];

    // The credit bounds the queries in flight plus the queued results.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CR_W'(DEPTH))
        else $error("query credit above queue depth");

    // A waiting result always holds a credit.
    a_result_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_credit != '0))
        else $error("result present without outstanding credit");

    // A write and a query never share the stage that drives the grid banks.
    a_bank_stage_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_v[MAP_STAGES] |-> !r_qry_v[MAP_STAGES])
        else $error("write and query in the bank access stage together");

    // An undefined result leaves the block with a zero value.
    a_undefined_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("undefined result with nonzero value");

endmodule

>>> tb/tb_grid_bilinear_edge_clamped.sv
// Self-checking testbench for grid_bilinear_edge_clamped: sample writes and
// interpolation queries go in, and each result is checked against a predictor.
// Depends on gbec_pkg and the RTL of the interpolator.
module tb_grid_bilinear_edge_clamped;

    localparam longint ONE       = 64'sd65536;
    localparam longint HALF      = 64'sd32768;
    localparam longint INT32_MAX = 64'sd2147483647;
    localparam longint INT32_MIN = -64'sd2147483648;
    localparam int     GRID_COLS = 64;

    typedef struct packed {
        logic [15:0] value;
        logic        defined;
    } t_interp_result;

    // Holds a copy of the registers and the grid, and the results still due.
    class interp_scoreboard;
        logic signed [31:0] org_x, org_y;
        logic [30:0]        scl_x, scl_y;
        logic [6:0]         col_reg, row_reg;
        logic signed [15:0] samples [GRID_COLS*GRID_COLS];
        bit                 written [GRID_COLS*GRID_COLS];
        t_interp_result     awaited_results [$];
        int                 errors;

        function new();
            org_x   = gbec_pkg::ORIGIN_RESET;
            org_y   = gbec_pkg::ORIGIN_RESET;
            scl_x   = gbec_pkg::SCALE_RESET;
            scl_y   = gbec_pkg::SCALE_RESET;
            col_reg = 7'(gbec_pkg::COUNT_RESET);
            row_reg = 7'(gbec_pkg::COUNT_RESET);
            errors  = 0;
        endfunction

        function void set_reg(logic [gbec_pkg::CFG_IDX_W-1:0] idx,
                              logic [gbec_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                gbec_pkg::REG_X_ORIGIN: org_x   = data;
                gbec_pkg::REG_X_SCALE:  scl_x   = data[30:0];
                gbec_pkg::REG_Y_ORIGIN: org_y   = data;
                gbec_pkg::REG_Y_SCALE:  scl_y   = data[30:0];
                gbec_pkg::REG_COLUMNS:  col_reg = data[6:0];
                gbec_pkg::REG_ROWS:     row_reg = data[6:0];
                default: ;
            endcase
        endfunction

        function int used(logic [6:0] count);
            if (count == 0)
                return 1;
            if (count > GRID_COLS)
                return GRID_COLS;
            return count;
        endfunction

        // One-based fractional index; the arithmetic shift floors the product.
        function longint axis_index(logic signed [31:0] coord, logic signed [31:0] origin,
                                    logic [30:0] scale);
            longint offset;
            offset = longint'(coord) - longint'(origin);
            return ((offset * longint'(scale)) >>> 16) + ONE;
        endfunction

        // Finds the four neighbours (zero-based, clamped) and the weights.
        function void locate(logic signed [31:0] x, logic signed [31:0] y, output bit defined,
                             output int bot, output int top, output int left,
                             output int right, output longint dr, output longint dc);
            longint cr, cc;
            int     nx, ny;
            nx = used(col_reg);
            ny = used(row_reg);
            cr = axis_index(y, org_y, scl_y);
            cc = axis_index(x, org_x, scl_x);
            defined = !(cr < HALF || cr > ny * ONE + HALF || cc < HALF || cc > nx * ONE + HALF);
            bot = 0; top = 0; left = 0; right = 0; dr = 0; dc = 0;
            if (defined) begin
                bot   = int'(cr >>> 16);
                left  = int'(cc >>> 16);
                dr    = cr - (longint'(bot) <<< 16);
                dc    = cc - (longint'(left) <<< 16);
                top   = bot + 1;
                right = left + 1;
                if (bot < 1) bot = 1;
                if (top > ny) top = ny;
                if (left < 1) left = 1;
                if (right > nx) right = nx;
                bot--; top--; left--; right--;
            end
        endfunction

        function t_interp_result interpolate(logic signed [31:0] x, logic signed [31:0] y);
            t_interp_result res;
            bit             defined;
            int             bot, top, left, right;
            longint         dr, dc, ab, at, mix;
            locate(x, y, defined, bot, top, left, right, dr, dc);
            res = '0;
            if (defined) begin
                ab = longint'(samples[bot*GRID_COLS+left]) * (ONE - dc)
                   + longint'(samples[bot*GRID_COLS+right]) * dc;
                at = longint'(samples[top*GRID_COLS+left]) * (ONE - dc)
                   + longint'(samples[top*GRID_COLS+right]) * dc;
                // Round to nearest with ties upward: add one half of 2^32, then floor.
                mix = (ab * (ONE - dr) + at * dr + (longint'(1) <<< 31)) >>> 32;
                res.value   = mix[15:0];
                res.defined = 1'b1;
            end
            return res;
        endfunction

        function void note_item(logic op, logic [5:0] row, logic [5:0] col,
                                logic [15:0] smp, logic [31:0] x, logic [31:0] y);
            if (op == gbec_pkg::OP_WRITE) begin
                samples[row*GRID_COLS+col] = smp;
                written[row*GRID_COLS+col] = 1'b1;
            end else begin
                awaited_results.push_back(interpolate(x, y));
            end
        endfunction

        function void check_result(logic [15:0] value, logic defined);
            t_interp_result exp_res;
            if (awaited_results.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result: value %0d defined %0b",
                             $signed(value), defined);
                errors++;
                return;
            end
            exp_res = awaited_results.pop_front();
            if (exp_res.value !== value || exp_res.defined !== defined) begin
                if (errors < 10)
                    $display("mismatch: expected value %0d defined %0b, got value %0d defined %0b",
                             $signed(exp_res.value), exp_res.defined, $signed(value), defined);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [95:0] i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_wr_en = 1'b0;
    logic [gbec_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [gbec_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    interp_scoreboard sb;
    int idle_pct = 35;

    grid_bilinear_edge_clamped dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Result side: check every transfer and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser);
        i_m_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic send_item(logic op, logic [5:0] row, logic [5:0] col, logic [15:0] smp,
                             logic [31:0] x, logic [31:0] y);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0, y, x, smp, col, row};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(op, row, col, smp, x, y);
    endtask

    task automatic send_write(int row, int col, logic [15:0] smp);
        send_item(gbec_pkg::OP_WRITE, row[5:0], col[5:0], smp, $urandom, $urandom);
    endtask

    task automatic fill_cell(int row, int col);
        if (!sb.written[row*GRID_COLS+col])
            send_write(row, col, 16'($urandom));
    endtask

    // Queries never touch an unwritten entry: missing neighbours are written first.
    task automatic send_query(logic [31:0] x, logic [31:0] y);
        bit     defined;
        int     bot, top, left, right;
        longint dr, dc;
        sb.locate(x, y, defined, bot, top, left, right, dr, dc);
        if (defined) begin
            fill_cell(bot, left);
            fill_cell(bot, right);
            fill_cell(top, left);
            fill_cell(top, right);
        end
        send_item(gbec_pkg::OP_QUERY, 6'($urandom), 6'($urandom), 16'($urandom), x, y);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        // Writes give no result and may still be in the pipeline.
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [gbec_pkg::CFG_IDX_W-1:0] idx,
                             logic [gbec_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_config(logic [31:0] xo, logic [31:0] xs, logic [31:0] yo,
                                logic [31:0] ys, logic [31:0] cols, logic [31:0] rows);
        cfg_write(gbec_pkg::REG_X_ORIGIN, xo);
        cfg_write(gbec_pkg::REG_X_SCALE, xs);
        cfg_write(gbec_pkg::REG_Y_ORIGIN, yo);
        cfg_write(gbec_pkg::REG_Y_SCALE, ys);
        cfg_write(gbec_pkg::REG_COLUMNS, cols);
        cfg_write(gbec_pkg::REG_ROWS, rows);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly aims at an index near or inside the used grid, sometimes on or just
    // beside a bound, sometimes anywhere.
    function automatic logic [31:0] aim_coord(logic signed [31:0] origin, logic [30:0] scale,
                                              int n);
        longint target, coord;
        int     pick;
        pick = $urandom_range(99);
        if (scale == 0 || pick < 15)
            return $urandom;
        if (pick < 30)
            target = ($urandom_range(1) ? longint'(n) * ONE + HALF : HALF)
                   + longint'($urandom_range(2)) - 1;
        else
            target = longint'($urandom_range(n * 65536 + 16384)) + HALF - 8192;
        coord = longint'(origin) + ((target - ONE) * ONE) / longint'(scale);
        if (coord > INT32_MAX) coord = INT32_MAX;
        if (coord < INT32_MIN) coord = INT32_MIN;
        return coord[31:0];
    endfunction

    task automatic random_items(int count);
        repeat (count) begin
            if ($urandom_range(99) < 30)
                send_write($urandom_range(63), $urandom_range(63), 16'($urandom));
            else
                send_query(aim_coord(sb.org_x, sb.scl_x, sb.used(sb.col_reg)),
                           aim_coord(sb.org_y, sb.scl_y, sb.used(sb.row_reg)));
        end
    endtask

    task automatic set_phase(int ph);
        idle_pct = (ph == 4) ? 0 : 35;
        case (ph)
            0: apply_config(32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd64);
            1: apply_config($urandom, $urandom_range(1 << 20, 1 << 12), $urandom,
                            $urandom_range(1 << 20, 1 << 12), $urandom_range(64, 1),
                            $urandom_range(64, 1));
            // Zero scale maps everything to index 1.0; the counts saturate.
            2: apply_config($urandom, 32'd0, $urandom, 32'd0, 32'd0, 32'd127);
            3: apply_config($urandom, $urandom, $urandom, $urandom, 32'd2, 32'd2);
            4: apply_config(32'h0001_0000, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'd64, 32'd1);
            default: apply_config($urandom, $urandom_range(1 << 18, 1 << 14), $urandom,
                                  $urandom_range(1 << 18, 1 << 14), $urandom_range(127),
                                  $urandom_range(127));
        endcase
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: origin 1.0 and scale 1.0 make the index equal the coordinate.
        send_write(0, 0, 16'h8000);
        send_write(0, 63, 16'h7FFF);
        send_write(63, 0, 16'h7FFF);
        send_write(63, 63, 16'h8000);
        send_write(10, 10, 16'h0000);
        send_write(10, 11, 16'h0001);
        send_write(11, 10, 16'hFFFF);
        send_write(11, 11, 16'h0000);
        send_query(32'h0001_0000, 32'h0001_0000);
        send_query(32'h0040_0000, 32'h0040_0000);
        send_query(32'h0000_8000, 32'h0000_8000);
        send_query(32'h0040_8000, 32'h0000_8000);
        send_query(32'h0000_7FFF, 32'h0001_0000);
        send_query(32'h0040_8001, 32'h0001_0000);
        send_query(32'h0001_0000, 32'h0040_8001);
        // Halfway ties: +0.5 rounds up to 1, -0.5 rounds up to 0.
        send_query(32'h000B_8000, 32'h000B_0000);
        send_query(32'h000B_8000, 32'h000C_0000);
        send_query(32'h000B_8000, 32'h000B_8000);
        send_query(32'h8000_0000, 32'h7FFF_FFFF);
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
        send_query(32'h0040_4000, 32'h0000_C000);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            set_phase(ph);
            if (ph == 1) begin
                random_items(35);
                drain();
                random_items(35);
            end else begin
                random_items(70);
            end
        end
        drain();

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(20 * 500000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
